@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dcq_pkg.sv @@
`default_nettype none
package dcq_pkg;

	// configuration register width and index map
	localparam int CFG_W = 13;
	typedef enum logic [1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_TARGET_WIDTH  = 2'd2,
		REG_TARGET_HEIGHT = 2'd3
	} cfg_reg_t;

	// register reset values
	localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 13'd480;
	localparam logic [CFG_W-1:0] RST_TARGET_WIDTH  = 13'd80;
	localparam logic [CFG_W-1:0] RST_TARGET_HEIGHT = 13'd24;

	// palette cube constants
	localparam logic [7:0] CUBE_BASE   = 8'd16;
	localparam logic [7:0] CUBE_RED_W  = 8'd36;
	localparam logic [7:0] CUBE_GREEN_W = 8'd6;

	// queue between classifier and quantizer
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       row_end;
		logic       frame_end;
	} cell_t;

	typedef struct packed {
		logic push;
		logic room;
	} queue_ctl_t;

	// level = floor((10c + 256) / 512), 0..5
	function automatic logic [2:0] cube_level(input logic [7:0] c);
		logic [11:0] t;
		t = 12'({c, 3'b000}) + 12'({c, 1'b0}) + 12'd256;
		return t[11:9];
	endfunction

	// 16 + 36r + 6g + b
	function automatic logic [7:0] cube_index(input cell_t c);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		r = 8'(cube_level(c.red));
		g = 8'(cube_level(c.green));
		b = 8'(cube_level(c.blue));
		return CUBE_BASE + 8'(CUBE_RED_W * r) + 8'(CUBE_GREEN_W * g) + b;
	endfunction

endpackage
`default_nettype wire

@@ rtl/dcq_front.sv @@
`default_nettype none
`include "assert_macros.svh"
module dcq_front #(
	parameter int MAX_DIMENSION = 4096,
	localparam int DW = $clog2(MAX_DIMENSION + 1),
	localparam int SUMW = 2 * DW + 1
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [dcq_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [7:0]               blue_level,
	input  wire logic [7:0]               green_level,
	input  wire logic [7:0]               red_level,
	output dcq_pkg::queue_ctl_t           qctl,
	input  wire logic                     q_room,
	output dcq_pkg::cell_t                q_data
);
	import dcq_pkg::*;

	// zero reads as one, oversize saturates
	function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w == 32'd0) return DW'(1);
		else if (w > 32'(MAX_DIMENSION)) return DW'(MAX_DIMENSION);
		else return DW'(w);
	endfunction

	logic [CFG_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic [DW-1:0] eff_sw_q, eff_sh_q, eff_tw_q, eff_th_q;
	logic [DW-1:0] cw, ch, csw, csh;
	logic settle_q;

	logic [DW-1:0] src_col_q, src_row_q, out_col_q, out_row_q;
	logic [SUMW-1:0] col_target_q, col_base_q, row_target_q, row_base_q;

	logic [SUMW-1:0] col_lim, row_lim;
	logic [DW-1:0] src_col_nx, src_row_nx, out_col_nx, out_row_nx;
	logic row_kept, cell_kept, row_done, frame_done, accept;

	// configuration registers, any write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= RST_SOURCE_WIDTH;
			src_h_q <= RST_SOURCE_HEIGHT;
			tgt_w_q <= RST_TARGET_WIDTH;
			tgt_h_q <= RST_TARGET_HEIGHT;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_SOURCE_WIDTH:  src_w_q <= cfg_data;
				REG_SOURCE_HEIGHT: src_h_q <= cfg_data;
				REG_TARGET_WIDTH:  tgt_w_q <= cfg_data;
				REG_TARGET_HEIGHT: tgt_h_q <= cfg_data;
				default: src_w_q <= src_w_q;
			endcase
		end
	end

	// effective sizes, clamped and registered behind the registers
	always_comb begin
		csw = clamp_dim(src_w_q);
		csh = clamp_dim(src_h_q);
		cw = clamp_dim(tgt_w_q);
		ch = clamp_dim(tgt_h_q);
	end

	always_ff @(posedge clk) begin
		eff_sw_q <= csw;
		eff_sh_q <= csh;
		eff_tw_q <= (cw > csw) ? csw : cw;
		eff_th_q <= (ch > csh) ? csh : ch;
	end

	// hold off input while effective sizes settle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) settle_q <= 1'b1;
		else settle_q <= cfg_write;
	end

	assign in_ready = !settle_q && q_room;
	assign accept = in_valid && in_ready;

	// keep decision for the current source position
	always_comb begin
		row_lim = row_base_q + SUMW'(eff_th_q);
		col_lim = col_base_q + SUMW'(eff_tw_q);
		row_kept = (out_row_q < eff_th_q) && (row_target_q < row_lim);
		cell_kept = row_kept && (out_col_q < eff_tw_q) && (col_target_q < col_lim);
		src_col_nx = src_col_q + DW'(1);
		src_row_nx = src_row_q + DW'(1);
		out_col_nx = out_col_q + DW'(1);
		out_row_nx = out_row_q + DW'(1);
		row_done = src_col_nx >= eff_sw_q;
		frame_done = src_row_nx >= eff_sh_q;
	end

	// kept cell to the queue
	always_comb begin
		qctl.push = accept && cell_kept;
		qctl.room = q_room;
		q_data.blue = blue_level;
		q_data.green = green_level;
		q_data.red = red_level;
		q_data.row_end = out_col_nx >= eff_tw_q;
		q_data.frame_end = (out_col_nx >= eff_tw_q) && (out_row_nx >= eff_th_q);
	end

	// position tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			col_target_q <= '0;
			col_base_q <= '0;
			row_target_q <= '0;
			row_base_q <= '0;
		end else if (cfg_write) begin
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			col_target_q <= '0;
			col_base_q <= '0;
			row_target_q <= '0;
			row_base_q <= '0;
		end else if (accept) begin
			if (row_done) begin
				src_col_q <= '0;
				out_col_q <= '0;
				col_target_q <= '0;
				col_base_q <= '0;
				if (frame_done) begin
					src_row_q <= '0;
					out_row_q <= '0;
					row_target_q <= '0;
					row_base_q <= '0;
				end else begin
					src_row_q <= src_row_nx;
					row_base_q <= row_base_q + SUMW'(eff_th_q);
					if (row_kept) begin
						out_row_q <= out_row_nx;
						row_target_q <= row_target_q + SUMW'(eff_sh_q);
					end
				end
			end else begin
				src_col_q <= src_col_nx;
				col_base_q <= col_lim;
				if (cell_kept) begin
					out_col_q <= out_col_nx;
					col_target_q <= col_target_q + SUMW'(eff_sw_q);
				end
			end
		end
	end

	`ASSERT_IMPLY(a_col_in_row, clk, arst_n, !settle_q, src_col_q < eff_sw_q,
		"source column past row width")
	`ASSERT_IMPLY(a_out_col_bound, clk, arst_n, !settle_q, out_col_q <= eff_tw_q,
		"output column past target width")

endmodule
`default_nettype wire

@@ rtl/dcq_queue.sv @@
`default_nettype none
`include "assert_macros.svh"
module dcq_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  dcq_pkg::queue_ctl_t      qctl,
	input  dcq_pkg::cell_t           wr_data,
	output logic                     room,
	output logic                     rd_valid,
	input  wire logic                pop,
	output dcq_pkg::cell_t           rd_data
);
	import dcq_pkg::*;

	cell_t slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0] count_q;
	logic do_pop;

	assign room = count_q != (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data = slot_q[rd_ptr_q];
	assign do_pop = pop && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (qctl.push) slot_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (qctl.push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			case ({qctl.push, do_pop})
				2'b10: count_q <= count_q + (QUEUE_AW + 1)'(1);
				2'b01: count_q <= count_q - (QUEUE_AW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH),
		"queue count past depth")
	`ASSERT_IMPLY(a_no_overflow, clk, arst_n, qctl.push, qctl.room,
		"push into full queue")

endmodule
`default_nettype wire

@@ rtl/dcq_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module dcq_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           rd_valid,
	input  dcq_pkg::cell_t      rd_data,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          color_index,
	output logic                row_end,
	output logic                frame_end
);
	import dcq_pkg::*;

	logic out_valid_q;
	logic [7:0] index_q;
	logic row_end_q, frame_end_q;

	// take the queue head whenever the output slot frees up
	assign pop = rd_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (pop) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	// quantize into the output register
	always_ff @(posedge clk) begin
		if (pop) begin
			index_q <= cube_index(rd_data);
			row_end_q <= rd_data.row_end;
			frame_end_q <= rd_data.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign color_index = index_q;
	assign row_end = row_end_q;
	assign frame_end = frame_end_q;

	`ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid_q && !out_ready && !pop, out_valid_q,
		"stalled result dropped")

endmodule
`default_nettype wire

@@ rtl/downscale_and_color_cube_quantize_top.sv @@
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     blue_level, green_level, red_level
// out       output     out_valid / out_ready   color_index, row_end, frame_end
// cfg       input      cfg_write               cfg_index, cfg_data
//
// one pixel per clock sustained while the queue has room; a kept pixel passes through the queue slot
// and the output register before it shows at the outputs; the rate is set by the position step in the classifier
// reset and every configuration write restart the frame; input is held off after
// reset and after each write while the effective sizes load
// a four-entry queue parts classifier and quantizer so output stalls do not stop input at once
`default_nettype none
module downscale_and_color_cube_quantize_top #(
	parameter int MAX_DIMENSION = 4096
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_write,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [dcq_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [7:0]                blue_level,
	input  wire logic [7:0]                green_level,
	input  wire logic [7:0]                red_level,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [7:0]                     color_index,
	output logic                           row_end,
	output logic                           frame_end
);
	import dcq_pkg::*;

	queue_ctl_t qctl;
	cell_t wr_data, rd_data;
	logic q_room, rd_valid, pop;

	dcq_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
		.clk, .arst_n, .cfg_write, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .blue_level, .green_level, .red_level,
		.qctl, .q_room, .q_data(wr_data)
	);

	dcq_queue u_queue (
		.clk, .arst_n, .qctl, .wr_data, .room(q_room),
		.rd_valid, .pop, .rd_data
	);

	dcq_back u_back (
		.clk, .arst_n, .rd_valid, .rd_data, .pop,
		.out_valid, .out_ready, .color_index, .row_end, .frame_end
	);

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import dcq_pkg::*;

	localparam int DIM_LIMIT = 4096;
	localparam int TOTAL_ITEMS = 1350;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 120;
	localparam int QUIET_LIMIT = 2000;
	localparam int PALETTE_BASE = 16;
	localparam int RED_STRIDE = 36;
	localparam int GREEN_STRIDE = 6;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} source_pixel_t;

	typedef struct packed {
		logic [7:0] color;
		logic       row_end;
		logic       frame_end;
	} palette_cell_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write = 1'b0;
	logic [1:0]       cfg_index = REG_SOURCE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       blue_level = '0;
	logic [7:0]       green_level = '0;
	logic [7:0]       red_level = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [7:0]       color_index;
	logic             row_end;
	logic             frame_end;

	downscale_and_color_cube_quantize_top #(
		.MAX_DIMENSION(DIM_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.blue_level(blue_level),
		.green_level(green_level),
		.red_level(red_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.color_index(color_index),
		.row_end(row_end),
		.frame_end(frame_end)
	);

	always #1 clk = ~clk;

	// shared between stimulus, driver and monitor
	source_pixel_t pending_pixels[$];
	palette_cell_t expected_cells[$];
	source_pixel_t next_pixel;
	palette_cell_t oldest_cell;
	int            error_count = 0;
	int            send_gap = 0;
	int            stall_left = 0;
	int            long_holds_requested = 0;
	int            long_holds_served = 0;
	int            quiet_cycles = 0;
	bit            sender_idle_on = 1'b1;
	bit            receiver_idle_on = 1'b1;

	// predictor copy of the size registers and scan position
	logic [CFG_W-1:0] size_src_w, size_src_h, size_tgt_w, size_tgt_h;
	logic [12:0]      scan_col, scan_row, cell_col, cell_row;
	logic [24:0]      col_pick_sum, col_limit_sum, row_pick_sum, row_limit_sum;

	// zero reads as one, oversize saturates
	function automatic logic [12:0] usable_size(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 13'd1;
		if (v > DIM_LIMIT)
			return 13'(DIM_LIMIT);
		return v;
	endfunction

	function automatic logic [12:0] cells_across();
		logic [12:0] t;
		logic [12:0] s;
		t = usable_size(size_tgt_w);
		s = usable_size(size_src_w);
		return (t > s) ? s : t;
	endfunction

	function automatic logic [12:0] cells_down();
		logic [12:0] t;
		logic [12:0] s;
		t = usable_size(size_tgt_h);
		s = usable_size(size_src_h);
		return (t > s) ? s : t;
	endfunction

	// rounded six-step level of one channel
	function automatic int shade_step(input logic [7:0] c);
		return (int'(c) * 10 + 256) / 512;
	endfunction

	function automatic void restart_scan_row();
		scan_col = '0;
		cell_col = '0;
		col_pick_sum = '0;
		col_limit_sum = 25'(cells_across());
	endfunction

	function automatic void restart_scan_frame();
		restart_scan_row();
		scan_row = '0;
		cell_row = '0;
		row_pick_sum = '0;
		row_limit_sum = 25'(cells_down());
	endfunction

	// advance the scan by one source pixel, queue the cell it yields
	task automatic scale_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
		logic [12:0]   sw, sh, tw, th;
		logic          row_kept, cell_kept;
		palette_cell_t kept_cell;
		sw = usable_size(size_src_w);
		sh = usable_size(size_src_h);
		tw = cells_across();
		th = cells_down();
		row_kept = (cell_row < th) && (row_pick_sum < row_limit_sum);
		cell_kept = row_kept && (cell_col < tw) && (col_pick_sum < col_limit_sum);
		if (cell_kept) begin
			kept_cell.color = 8'(PALETTE_BASE + RED_STRIDE * shade_step(r) +
				GREEN_STRIDE * shade_step(g) + shade_step(b));
			kept_cell.row_end = (cell_col + 13'd1 >= tw);
			kept_cell.frame_end = kept_cell.row_end && (cell_row + 13'd1 >= th);
			expected_cells.push_back(kept_cell);
			cell_col = cell_col + 13'd1;
			col_pick_sum = col_pick_sum + 25'(sw);
		end
		col_limit_sum = col_limit_sum + 25'(tw);
		scan_col = scan_col + 13'd1;
		if (scan_col >= sw) begin
			restart_scan_row();
			if (row_kept) begin
				cell_row = cell_row + 13'd1;
				row_pick_sum = row_pick_sum + 25'(sh);
			end
			scan_row = scan_row + 13'd1;
			row_limit_sum = row_limit_sum + 25'(th);
			if (scan_row >= sh)
				restart_scan_frame();
		end
	endtask

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// channel values on both sides of each level step, plus the ends
	function automatic logic [7:0] level_boundary(input int k);
		case (k)
			0: return 8'd0;
			1: return 8'd25;
			2: return 8'd26;
			3: return 8'd76;
			4: return 8'd77;
			5: return 8'd127;
			6: return 8'd128;
			7: return 8'd179;
			8: return 8'd180;
			9: return 8'd230;
			10: return 8'd231;
			default: return 8'd255;
		endcase
	endfunction

	function automatic logic [7:0] random_channel();
		if ($urandom_range(0, 4) == 0)
			return level_boundary($urandom_range(0, 11));
		return 8'($urandom);
	endfunction

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			// pixel transaction accepted at this edge
			if (in_valid && in_ready)
				scale_pixel(blue_level, green_level, red_level);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					next_pixel = pending_pixels.pop_front();
					in_valid <= 1'b1;
					blue_level <= next_pixel.blue;
					green_level <= next_pixel.green;
					red_level <= next_pixel.red;
					send_gap = sender_idle_on ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// cell monitor and receiver pacing
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			// compare a cell transaction with the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_cells.size() == 0) begin
					error_count++;
					$display("%0t: unexpected cell, got color %0d row_end %0b frame_end %0b",
						$time, color_index, row_end, frame_end);
				end else begin
					oldest_cell = expected_cells.pop_front();
					if (color_index !== oldest_cell.color) begin
						error_count++;
						$display("%0t: color_index mismatch, expected %0d, got %0d",
							$time, oldest_cell.color, color_index);
					end
					if (row_end !== oldest_cell.row_end) begin
						error_count++;
						$display("%0t: row_end mismatch, expected %0b, got %0b",
							$time, oldest_cell.row_end, row_end);
					end
					if (frame_end !== oldest_cell.frame_end) begin
						error_count++;
						$display("%0t: frame_end mismatch, expected %0b, got %0b",
							$time, oldest_cell.frame_end, frame_end);
					end
				end
			end
			// decide ready for the next cycle
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (long_holds_served != long_holds_requested) begin
				long_holds_served = long_holds_requested;
				stall_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (receiver_idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// wait until every pixel is sent and every cell has come out
	task automatic wait_drained();
		@(posedge clk);
		while (pending_pixels.size() != 0 || in_valid || expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t which, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// load all four sizes; the block restarts its frame on each write
	task automatic set_sizes(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
		input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th);
		write_register(REG_SOURCE_WIDTH, sw);
		write_register(REG_SOURCE_HEIGHT, sh);
		write_register(REG_TARGET_WIDTH, tw);
		write_register(REG_TARGET_HEIGHT, th);
		size_src_w = sw;
		size_src_h = sh;
		size_tgt_w = tw;
		size_tgt_h = th;
		restart_scan_frame();
	endtask

	task automatic queue_random_pixels(input int count, inout int planned);
		source_pixel_t p;
		repeat (count) begin
			p.blue = random_channel();
			p.green = random_channel();
			p.red = random_channel();
			pending_pixels.push_back(p);
		end
		planned += count;
	endtask

	// stimulus
	initial begin
		int            planned;
		int            frame_pixels;
		int            count;
		logic [12:0]   sw, sh, tw, th;
		source_pixel_t p;
		planned = 0;
		size_src_w = RST_SOURCE_WIDTH;
		size_src_h = RST_SOURCE_HEIGHT;
		size_tgt_w = RST_TARGET_WIDTH;
		size_tgt_h = RST_TARGET_HEIGHT;
		restart_scan_frame();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// sizes out of reset
		queue_random_pixels(16, planned);
		wait_drained();

		// one to one grid: every level step, row and frame ends
		set_sizes(13'd5, 13'd5, 13'd5, 13'd5);
		for (int k = 0; k < 25; k++) begin
			p.blue = level_boundary(k % 12);
			p.green = level_boundary((k + 4) % 12);
			p.red = level_boundary((k + 8) % 12);
			if (k == 12)
				p = '1;
			pending_pixels.push_back(p);
		end
		planned += 25;
		wait_drained();

		// zero sizes read as one
		set_sizes(13'd0, 13'd0, 13'd0, 13'd0);
		queue_random_pixels(10, planned);
		wait_drained();
		// oversize widths and heights saturate
		set_sizes(13'd8191, 13'd2, 13'd8191, 13'd1);
		queue_random_pixels(30, planned);
		wait_drained();
		set_sizes(13'd4096, 13'd4096, 13'd1000, 13'd4096);
		queue_random_pixels(30, planned);
		wait_drained();
		set_sizes(13'd1, 13'd4096, 13'd1, 13'd2000);
		queue_random_pixels(30, planned);
		wait_drained();
		set_sizes(13'd4097, 13'd8191, 13'd4096, 13'd1);
		queue_random_pixels(20, planned);
		wait_drained();
		// upscale request clamps to the source size
		set_sizes(13'd3, 13'd2, 13'd8191, 13'd4096);
		queue_random_pixels(18, planned);
		wait_drained();

		// back pressure: receiver holds off while the sender streams
		set_sizes(13'd8, 13'd8, 13'd8, 13'd8);
		sender_idle_on = 1'b0;
		receiver_idle_on = 1'b0;
		long_holds_requested++;
		queue_random_pixels(150, planned);
		wait_drained();
		// sender paused until drained, then resumes mid frame
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
		queue_random_pixels(50, planned);
		wait_drained();

		// random small frames, some with saturating or zero sizes
		while (planned < TOTAL_ITEMS) begin
			sw = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 40))
				: 13'($urandom_range(1, 12));
			sh = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 8));
			tw = 13'($urandom_range(0, int'(sw) + 3));
			th = 13'($urandom_range(0, int'(sh) + 2));
			sender_idle_on = ($urandom_range(0, 3) != 0);
			receiver_idle_on = ($urandom_range(0, 3) != 0);
			set_sizes(sw, sh, tw, th);
			frame_pixels = int'(usable_size(sw)) * int'(usable_size(sh));
			count = frame_pixels * $urandom_range(1, 2) + $urandom_range(0, frame_pixels);
			if (count > 150)
				count = 150;
			queue_random_pixels(count, planned);
			wait_drained();
		end

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
